[src/lrn_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lrn_pkg
// Shared types and constants of the linear recurrence term unit.
// ----------------------------------------------------------------------------
package lrn_pkg;

	localparam int DEF_MAX_ORDER = 16;

	// Prime modulus and the Barrett factor floor(2^61 / modulus).
	localparam logic [29:0] MODP       = 30'd1000000007;
	localparam logic [31:0] BARRETT_MU = 32'((64'd1 << 61) / 64'd1000000007);

	localparam logic [1:0] ACT_LOAD_COEF = 2'd0;
	localparam logic [1:0] ACT_LOAD_INIT = 2'd1;
	localparam logic [1:0] ACT_QUERY     = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ZERO,
		ST_DIRECT,
		ST_INIT,
		ST_MUL,
		ST_MUL_WAIT,
		ST_COPY,
		ST_COPY_WAIT,
		ST_DOT,
		ST_DOT_WAIT,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic load_coef;
		logic load_init;
		logic init_we;
		logic mac_valid;
		logic mac_first;
		logic mac_last;
		logic x_from_a;
		logic y_from_init;
		logic dst_out;
		logic copy_valid;
		logic copy_to_a;
		logic cap_zero;
		logic cap_init;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic busy;
	} dp_status_t;

endpackage
`default_nettype wire

[src/lrn_modmac.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lrn_modmac
// Pipelined modular multiply-accumulate with Barrett reduction.
// ----------------------------------------------------------------------------
module lrn_modmac #(
	parameter int TW = 9
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire logic          in_first,
	input  wire logic          in_last,
	input  wire logic [TW-1:0] in_tag,
	input  wire logic [29:0]   a,
	input  wire logic [29:0]   b,
	output logic               res_valid,
	output logic [TW-1:0]      res_tag,
	output logic [29:0]        res_value,
	output logic               busy
);
	import lrn_pkg::*;

	logic [4:0]    v_q;
	logic [4:0]    f_q;
	logic [4:0]    l_q;
	logic [TW-1:0] t_s1, t_s2, t_s3, t_s4, t_s5;
	logic [59:0]   prod_s1, x_s2;
	logic [62:0]   qm_s2;
	logic [31:0]   xl_s3, qp_s3, r_s4;
	logic [29:0]   r_s5;
	logic [29:0]   acc_q;
	logic          res_valid_q;
	logic [TW-1:0] res_tag_q;

	logic [59:0] prod;
	logic [62:0] qm;
	logic [60:0] qp;
	logic [30:0] q;
	logic [31:0] r1, r2;
	logic [30:0] sum;
	logic [29:0] acc_next;

	assign prod = a * b;
	assign qm   = 63'(prod_s1[59:29]) * 63'(BARRETT_MU);
	assign q    = qm_s2[62:32];
	assign qp   = 61'(q) * 61'(MODP);

	// The Barrett estimate is short by at most two multiples of the modulus.
	always_comb begin
		r1 = (r_s4 >= {2'b00, MODP}) ? r_s4 - {2'b00, MODP} : r_s4;
		r2 = (r1 >= {2'b00, MODP}) ? r1 - {2'b00, MODP} : r1;
		sum = {1'b0, (f_q[4] ? 30'd0 : acc_q)} + {1'b0, r_s5};
		acc_next = (sum >= {1'b0, MODP}) ? 30'(sum - {1'b0, MODP}) : sum[29:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q         <= '0;
			res_valid_q <= 1'b0;
		end else begin
			v_q         <= {v_q[3:0], in_valid};
			res_valid_q <= v_q[4] && l_q[4];
		end
	end

	always_ff @(posedge clk) begin
		f_q       <= {f_q[3:0], in_first};
		l_q       <= {l_q[3:0], in_last};
		t_s1      <= in_tag;
		t_s2      <= t_s1;
		t_s3      <= t_s2;
		t_s4      <= t_s3;
		t_s5      <= t_s4;
		prod_s1   <= prod;
		x_s2      <= prod_s1;
		qm_s2     <= qm;
		xl_s3     <= x_s2[31:0];
		qp_s3     <= qp[31:0];
		r_s4      <= xl_s3 - qp_s3;
		r_s5      <= r2[29:0];
		res_tag_q <= t_s5;
		if (v_q[4]) begin
			acc_q <= acc_next;
		end
	end

	assign res_valid = res_valid_q;
	assign res_tag   = res_tag_q;
	assign res_value = acc_q;
	assign busy      = (|v_q) || res_valid_q;

endmodule
`default_nettype wire

[src/lrn_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lrn_datapath
// Coefficient and initial stores, working matrices and the shared MAC.
// ----------------------------------------------------------------------------
module lrn_datapath #(
	parameter int MAX_ORDER = lrn_pkg::DEF_MAX_ORDER
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire lrn_pkg::dp_cmd_t     cmd,
	input  wire logic [((MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1)-1:0] i_idx,
	input  wire logic [((MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1)-1:0] j_idx,
	input  wire logic [((MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1)-1:0] k_idx,
	input  wire logic [((MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1)-1:0] m_last,
	input  wire logic [3:0]           slot,
	input  wire logic [29:0]          value,
	output lrn_pkg::dp_status_t       status,
	output logic [29:0]               term_value
);
	import lrn_pkg::*;

	localparam int IW  = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
	localparam int MSZ = MAX_ORDER * MAX_ORDER;
	localparam int AW  = (MSZ > 1) ? $clog2(MSZ) : 1;

	function automatic logic [AW-1:0] cell_addr(input logic [IW-1:0] r, input logic [IW-1:0] c);
		cell_addr = AW'(int'(r) * MAX_ORDER + int'(c));
	endfunction

	logic [29:0] coef_q [MAX_ORDER];
	logic [29:0] init_q [MAX_ORDER];
	logic [29:0] pm [MSZ];
	logic [29:0] am [MSZ];
	logic [29:0] sm [MSZ];

	logic [29:0] pm_rda_q, pm_rdb_q, am_rd_q, sm_rd_q, init_rd_q;
	logic [29:0] result_q, out_q;

	logic          mac_v_s0, mac_f_s0, mac_l_s0, xa_s0, yi_s0;
	logic [AW:0]   tag_s0;
	logic          copy_v_s0, copy_a_s0;
	logic [AW-1:0] copy_addr_s0;

	logic [AW-1:0] addr_x, addr_y, addr_ij;
	logic [29:0]   value_red, p_init, a_init;
	logic          pm_we, am_we;
	logic [AW-1:0] pm_waddr, am_waddr;
	logic [29:0]   pm_wdata, am_wdata;
	logic          res_valid, mac_busy;
	logic [AW:0]   res_tag;
	logic [29:0]   res_value;

	assign addr_x  = cell_addr(i_idx, k_idx);
	assign addr_y  = cell_addr(k_idx, j_idx);
	assign addr_ij = cell_addr(i_idx, j_idx);

	assign value_red = (value >= MODP) ? value - MODP : value;

	// Companion matrix: last row holds the coefficients, superdiagonal ones.
	always_comb begin
		if (i_idx == m_last) begin
			p_init = coef_q[j_idx];
		end else if ({1'b0, j_idx} == {1'b0, i_idx} + 1'b1) begin
			p_init = 30'd1;
		end else begin
			p_init = 30'd0;
		end
		a_init = (i_idx == j_idx) ? 30'd1 : 30'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int n = 0; n < MAX_ORDER; n++) begin
				coef_q[n] <= '0;
				init_q[n] <= '0;
			end
		end else if (int'(slot) < MAX_ORDER) begin
			if (cmd.load_coef) begin
				coef_q[IW'(slot)] <= value_red;
			end
			if (cmd.load_init) begin
				init_q[IW'(slot)] <= value_red;
			end
		end
	end

	always_comb begin
		pm_we    = cmd.init_we || (copy_v_s0 && !copy_a_s0);
		pm_waddr = cmd.init_we ? addr_ij : copy_addr_s0;
		pm_wdata = cmd.init_we ? p_init : sm_rd_q;
		am_we    = cmd.init_we || (copy_v_s0 && copy_a_s0);
		am_waddr = cmd.init_we ? addr_ij : copy_addr_s0;
		am_wdata = cmd.init_we ? a_init : sm_rd_q;
	end

	always_ff @(posedge clk) begin
		if (pm_we) begin
			pm[pm_waddr] <= pm_wdata;
		end
		pm_rda_q <= pm[addr_x];
		pm_rdb_q <= pm[addr_y];
	end

	always_ff @(posedge clk) begin
		if (am_we) begin
			am[am_waddr] <= am_wdata;
		end
		am_rd_q <= am[addr_x];
	end

	always_ff @(posedge clk) begin
		if (res_valid && !res_tag[AW]) begin
			sm[res_tag[AW-1:0]] <= res_value;
		end
		sm_rd_q <= sm[addr_ij];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mac_v_s0  <= 1'b0;
			copy_v_s0 <= 1'b0;
		end else begin
			mac_v_s0  <= cmd.mac_valid;
			copy_v_s0 <= cmd.copy_valid;
		end
	end

	always_ff @(posedge clk) begin
		init_rd_q    <= init_q[k_idx];
		mac_f_s0     <= cmd.mac_first;
		mac_l_s0     <= cmd.mac_last;
		xa_s0        <= cmd.x_from_a;
		yi_s0        <= cmd.y_from_init;
		tag_s0       <= {cmd.dst_out, addr_ij};
		copy_a_s0    <= cmd.copy_to_a;
		copy_addr_s0 <= addr_ij;
		if (cmd.cap_zero) begin
			result_q <= '0;
		end else if (cmd.cap_init) begin
			result_q <= init_q[k_idx];
		end else if (res_valid && res_tag[AW]) begin
			result_q <= res_value;
		end
		if (cmd.out_load) begin
			out_q <= result_q;
		end
	end

	lrn_modmac #(
		.TW(AW + 1)
	) u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (mac_v_s0),
		.in_first (mac_f_s0),
		.in_last  (mac_l_s0),
		.in_tag   (tag_s0),
		.a        (xa_s0 ? am_rd_q : pm_rda_q),
		.b        (yi_s0 ? init_rd_q : pm_rdb_q),
		.res_valid(res_valid),
		.res_tag  (res_tag),
		.res_value(res_value),
		.busy     (mac_busy)
	);

	assign status.busy = mac_busy || mac_v_s0 || copy_v_s0;
	assign term_value  = out_q;

endmodule
`default_nettype wire

[src/lrn_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lrn_ctrl
// Sequencer for loads, square-and-multiply and the final dot product.
// ----------------------------------------------------------------------------
module lrn_ctrl #(
	parameter int MAX_ORDER = lrn_pkg::DEF_MAX_ORDER
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [1:0]           action,
	input  wire logic [62:0]          term_index,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	input  wire logic                 cfg_we,
	input  wire logic [4:0]           cfg_wdata,
	input  wire lrn_pkg::dp_status_t  status,
	output lrn_pkg::dp_cmd_t          cmd,
	output logic [((MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1)-1:0] i_idx,
	output logic [((MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1)-1:0] j_idx,
	output logic [((MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1)-1:0] k_idx,
	output logic [((MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1)-1:0] m_last
);
	import lrn_pkg::*;

	localparam int IW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;

	state_t        state_q, state_d;
	logic [4:0]    order_q;
	logic [IW-1:0] m_last_q, i_q, j_q, k_q;
	logic [62:0]   exp_q;
	logic          sq_q;
	logic          out_valid_q;

	int            m_int;
	logic          start, q_zero, q_direct;
	logic          k_end, ij_end, ijk_end, out_free;

	always_comb begin
		m_int    = (int'(order_q) > MAX_ORDER) ? MAX_ORDER : int'(order_q);
		start    = (state_q == ST_IDLE) && in_valid && (action == ACT_QUERY);
		q_zero   = (order_q == 5'd0);
		q_direct = term_index < 63'(m_int);
		k_end    = (k_q == m_last_q);
		ij_end   = (i_q == m_last_q) && (j_q == m_last_q);
		ijk_end  = ij_end && k_end;
		out_free = !out_valid_q || out_ready;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (q_zero) begin
						state_d = ST_ZERO;
					end else if (q_direct) begin
						state_d = ST_DIRECT;
					end else begin
						state_d = ST_INIT;
					end
				end
			end
			ST_ZERO, ST_DIRECT: state_d = ST_FINISH;
			ST_INIT: if (ij_end) state_d = ST_MUL;
			ST_MUL: if (ijk_end) state_d = ST_MUL_WAIT;
			ST_MUL_WAIT: if (!status.busy) state_d = ST_COPY;
			ST_COPY: if (ij_end) state_d = ST_COPY_WAIT;
			ST_COPY_WAIT: begin
				if (!status.busy) begin
					state_d = (!sq_q && exp_q == 63'd1) ? ST_DOT : ST_MUL;
				end
			end
			ST_DOT: if (k_end) state_d = ST_DOT_WAIT;
			ST_DOT_WAIT: if (!status.busy) state_d = ST_FINISH;
			ST_FINISH: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready      = 1'b1;
				cmd.load_coef = in_valid && (action == ACT_LOAD_COEF);
				cmd.load_init = in_valid && (action == ACT_LOAD_INIT);
			end
			ST_ZERO:   cmd.cap_zero = 1'b1;
			ST_DIRECT: cmd.cap_init = 1'b1;
			ST_INIT:   cmd.init_we  = 1'b1;
			ST_MUL: begin
				cmd.mac_valid = 1'b1;
				cmd.mac_first = (k_q == '0);
				cmd.mac_last  = k_end;
				cmd.x_from_a  = !sq_q;
			end
			ST_COPY: begin
				cmd.copy_valid = 1'b1;
				cmd.copy_to_a  = !sq_q;
			end
			ST_DOT: begin
				cmd.mac_valid   = 1'b1;
				cmd.mac_first   = (k_q == '0);
				cmd.mac_last    = k_end;
				cmd.x_from_a    = 1'b1;
				cmd.y_from_init = 1'b1;
				cmd.dst_out     = 1'b1;
			end
			ST_FINISH: cmd.out_load = out_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			order_q     <= 5'd1;
			out_valid_q <= 1'b0;
			m_last_q    <= '0;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			exp_q       <= '0;
			sq_q        <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				order_q <= cfg_wdata;
			end
			if (state_q == ST_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						exp_q    <= term_index;
						sq_q     <= !term_index[0];
						m_last_q <= IW'(m_int - 1);
						i_q      <= '0;
						j_q      <= '0;
						k_q      <= q_direct ? term_index[IW-1:0] : '0;
					end
				end
				ST_INIT, ST_COPY: begin
					if (j_q == m_last_q) begin
						j_q <= '0;
						i_q <= (i_q == m_last_q) ? '0 : i_q + 1'b1;
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				ST_MUL: begin
					if (k_end) begin
						k_q <= '0;
						if (j_q == m_last_q) begin
							j_q <= '0;
							i_q <= (i_q == m_last_q) ? '0 : i_q + 1'b1;
						end else begin
							j_q <= j_q + 1'b1;
						end
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				ST_DOT: k_q <= k_end ? '0 : k_q + 1'b1;
				ST_COPY_WAIT: begin
					// A finished squaring consumes one exponent bit.
					if (!status.busy) begin
						if (sq_q) begin
							exp_q <= exp_q >> 1;
							sq_q  <= !exp_q[1];
						end else begin
							sq_q <= 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign i_idx     = i_q;
	assign j_idx     = j_q;
	assign k_idx     = k_q;
	assign m_last    = m_last_q;

endmodule
`default_nettype wire

[src/linear_recurrence_nth_term_mod_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// linear_recurrence_nth_term_mod_unit
// Term n of an order-m linear recurrence mod 1000000007 by companion
// matrix square-and-multiply on one pipelined modular MAC.
// Loads and unused actions are accepted back to back, one per cycle, while no query is in progress.
// A query for order zero or for n below the order captures its result in ST_ZERO or
// ST_DIRECT; ST_FINISH presents it once the output is free and returns to idle for input.
// Other queries build the companion and identity matrices, then run at most
// P = 2*floor(log2(n))+1 matrix products on the shared MAC and a final dot product.
// Reset clears both stores and sets the order to one; no clearing pass.
// ----------------------------------------------------------------------------
module linear_recurrence_nth_term_mod_unit #(
	parameter int MAX_ORDER = lrn_pkg::DEF_MAX_ORDER
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  action,
	input  wire logic [3:0]  slot,
	input  wire logic [29:0] value,
	input  wire logic [62:0] term_index,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [29:0]      term_value,
	input  wire logic        cfg_we,
	input  wire logic [4:0]  cfg_wdata
);
	import lrn_pkg::*;

	localparam int IW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;

	dp_cmd_t       cmd;
	dp_status_t    status;
	logic [IW-1:0] i_idx, j_idx, k_idx, m_last;

	lrn_ctrl #(
		.MAX_ORDER(MAX_ORDER)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.action    (action),
		.term_index(term_index),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.status    (status),
		.cmd       (cmd),
		.i_idx     (i_idx),
		.j_idx     (j_idx),
		.k_idx     (k_idx),
		.m_last    (m_last)
	);

	lrn_datapath #(
		.MAX_ORDER(MAX_ORDER)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.i_idx     (i_idx),
		.j_idx     (j_idx),
		.k_idx     (k_idx),
		.m_last    (m_last),
		.slot      (slot),
		.value     (value),
		.status    (status),
		.term_value(term_value)
	);

endmodule
`default_nettype wire

[src/lrn_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lrn_checker
// Port-level checks of the linear recurrence term unit.
// ----------------------------------------------------------------------------
module lrn_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic [1:0]  action,
	input wire logic [3:0]  slot,
	input wire logic [29:0] value,
	input wire logic [62:0] term_index,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [29:0] term_value,
	input wire logic        cfg_we,
	input wire logic [4:0]  cfg_wdata
);
	import lrn_pkg::*;

	// A pending result transaction holds until taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(term_value))
		else $error("result changed or dropped while stalled");

	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> term_value < MODP)
		else $error("result not reduced");

	// A query keeps the unit busy for at least the following cycle.
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && action == ACT_QUERY |=> !in_ready)
		else $error("input ready right after a query");

	// Loads never produce a result.
	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && action != ACT_QUERY && !out_valid |=> !out_valid)
		else $error("result after a load");

endmodule

bind linear_recurrence_nth_term_mod_unit lrn_checker u_lrn_checker (.*);
`default_nettype wire

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// Linear recurrence term unit testbench
// Sends coefficient loads, initial value loads and term queries over the
// valid/ready input channel, predicts each term with a behavioral companion
// matrix model or a directed value, and checks every returned term in order.
// Phases rewrite the order register and rotate through four idle/stall patterns.
// ----------------------------------------------------------------------------
module tb_top;
	import lrn_pkg::*;

	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam longint unsigned PRIME = 64'd1000000007;
	localparam logic [62:0] N_MAX = {63{1'b1}};
	localparam int SETTLE = 20;

	typedef bit [29:0] mat_t [0:15][0:15];
	typedef enum bit {ROW_ITEM, ROW_ORDER} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		logic [1:0]  act;
		logic [3:0]  pos;
		logic [29:0] val;
		logic [62:0] n;
		bit          typed;
		logic [29:0] term;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  action;
	logic [3:0]  slot;
	logic [29:0] value;
	logic [62:0] term_index;
	logic        out_valid;
	logic        out_ready;
	logic [29:0] term_value;
	logic        cfg_we;
	logic [4:0]  cfg_wdata;

	bit [29:0] coef_mem [0:15];
	bit [29:0] init_mem [0:15];
	bit [4:0]  order_reg;
	logic [29:0] pending_terms [$];
	int fails;
	int idle_pct;
	int stall_pct;

	linear_recurrence_nth_term_mod_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.action(action), .slot(slot), .value(value), .term_index(term_index),
		.out_valid(out_valid), .out_ready(out_ready), .term_value(term_value),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#30000000;
		$display("simulation failed");
		$finish;
	end

	function automatic bit [29:0] mul_mod(bit [29:0] x, bit [29:0] y);
		longint unsigned prod;
		prod = longint'(x) * longint'(y);
		return 30'(prod % PRIME);
	endfunction

	function automatic bit [29:0] add_mod(bit [29:0] x, bit [29:0] y);
		longint unsigned s;
		s = longint'(x) + longint'(y);
		return 30'(s % PRIME);
	endfunction

	function automatic mat_t mat_product(mat_t x, mat_t y, int m);
		mat_t r;
		bit [29:0] acc;
		r = x;
		for (int i = 0; i < m; i++)
			for (int j = 0; j < m; j++) begin
				acc = '0;
				for (int k = 0; k < m; k++)
					acc = add_mod(acc, mul_mod(x[i][k], y[k][j]));
				r[i][j] = acc;
			end
		return r;
	endfunction

	function automatic bit [29:0] nth_term(logic [62:0] n);
		int m;
		mat_t pw, ac;
		bit [62:0] e;
		bit [29:0] acc;
		m = (order_reg > 16) ? 16 : int'(order_reg);
		if (m == 0)
			return '0;
		if (n < 63'(m))
			return init_mem[n[3:0]];
		for (int i = 0; i < 16; i++)
			for (int j = 0; j < 16; j++) begin
				pw[i][j] = '0;
				ac[i][j] = '0;
			end
		for (int i = 0; i < m; i++) begin
			pw[m-1][i] = coef_mem[i];
			ac[i][i] = 30'd1;
		end
		for (int i = 1; i < m; i++)
			pw[i-1][i] = 30'd1;
		e = n;
		while (e != 0) begin
			if (e[0])
				ac = mat_product(ac, pw, m);
			pw = mat_product(pw, pw, m);
			e = e >> 1;
		end
		acc = '0;
		for (int i = 0; i < m; i++)
			acc = add_mod(acc, mul_mod(ac[0][i], init_mem[i]));
		return acc;
	endfunction

	// Updates the stores; returns 1 with the term when the transaction is a query.
	function automatic bit apply_item(logic [1:0] act, logic [3:0] pos, logic [29:0] val,
			logic [62:0] n, output logic [29:0] term);
		bit [29:0] v;
		v = (val >= 30'(PRIME)) ? val - 30'(PRIME) : val;
		term = '0;
		case (act)
			ACT_LOAD_COEF: coef_mem[pos] = v;
			ACT_LOAD_INIT: init_mem[pos] = v;
			ACT_QUERY: begin
				term = nth_term(n);
				return 1'b1;
			end
			default: ;
		endcase
		return 1'b0;
	endfunction

	task automatic send(logic [1:0] act, logic [3:0] pos, logic [29:0] val, logic [62:0] n,
			bit typed, logic [29:0] typed_term);
		logic [29:0] t;
		if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(0, 99) < idle_pct)
				@(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		slot <= pos;
		value <= val;
		term_index <= n;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (apply_item(act, pos, val, n, t))
			pending_terms.push_back(typed ? typed_term : t);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_terms.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_order(logic [4:0] ord);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= ord;
		@(posedge clk);
		cfg_we <= 1'b0;
		order_reg = ord;
	endtask

	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_terms.size() == 0) begin
				$error("term_value: none expected, actual %0d", term_value);
				fails++;
			end else begin
				if (term_value !== pending_terms[0]) begin
					$error("term_value: expected %0d, actual %0d",
						pending_terms[0], term_value);
					fails++;
				end
				void'(pending_terms.pop_front());
			end
		end
	end

	row_t directed [] = '{
		'{ROW_ITEM, ACT_QUERY, 4'd0, 30'd0, 63'd0, 1, 30'd0},
		'{ROW_ITEM, ACT_QUERY, 4'd0, 30'd0, N_MAX, 1, 30'd0},
		'{ROW_ITEM, ACT_LOAD_COEF, 4'd0, 30'd1000000006, 63'd0, 0, 30'd0},
		'{ROW_ITEM, ACT_LOAD_INIT, 4'd0, 30'h3fffffff, 63'd0, 0, 30'd0},
		'{ROW_ITEM, ACT_QUERY, 4'd0, 30'd0, 63'd1, 0, 30'd0},
		'{ROW_ITEM, ACT_QUERY, 4'd0, 30'd0, 63'd0, 1, 30'd73741816},
		'{ROW_ITEM, ACT_UNUSED, 4'd15, 30'h3fffffff, N_MAX, 0, 30'd0},
		'{ROW_ITEM, ACT_LOAD_COEF, 4'd15, 30'd0, 63'd0, 0, 30'd0},
		'{ROW_ITEM, ACT_LOAD_INIT, 4'd15, 30'd5, 63'd0, 0, 30'd0},
		'{ROW_ORDER, ACT_QUERY, 4'd0, 30'd0, 63'd0, 0, 30'd0},
		'{ROW_ITEM, ACT_QUERY, 4'd0, 30'd0, 63'd7, 1, 30'd0},
		'{ROW_ORDER, ACT_QUERY, 4'd0, 30'd31, 63'd0, 0, 30'd0},
		'{ROW_ITEM, ACT_QUERY, 4'd0, 30'd0, 63'd15, 1, 30'd5},
		'{ROW_ITEM, ACT_QUERY, 4'd0, 30'd0, 63'd100, 0, 30'd0},
		'{ROW_ORDER, ACT_QUERY, 4'd0, 30'd2, 63'd0, 0, 30'd0},
		'{ROW_ITEM, ACT_LOAD_COEF, 4'd0, 30'd1, 63'd0, 0, 30'd0},
		'{ROW_ITEM, ACT_LOAD_COEF, 4'd1, 30'd1, 63'd0, 0, 30'd0},
		'{ROW_ITEM, ACT_LOAD_INIT, 4'd0, 30'd0, 63'd0, 0, 30'd0},
		'{ROW_ITEM, ACT_LOAD_INIT, 4'd1, 30'd1, 63'd0, 0, 30'd0},
		'{ROW_ITEM, ACT_QUERY, 4'd0, 30'd0, 63'd10, 1, 30'd55},
		'{ROW_ITEM, ACT_QUERY, 4'd0, 30'd0, N_MAX, 0, 30'd0}
	};

	int phase_orders [] = '{3, 5, 2, 7, 4, 1};

	initial begin
		int sent;
		int pick;
		int bits;
		int m;
		logic [62:0] n;
		logic [29:0] val;
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = ACT_LOAD_COEF;
		slot = '0;
		value = '0;
		term_index = '0;
		out_ready = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		fails = 0;
		idle_pct = 0;
		stall_pct = 0;
		order_reg = 5'd1;
		for (int i = 0; i < 16; i++) begin
			coef_mem[i] = '0;
			init_mem[i] = '0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			if (directed[i].kind == ROW_ORDER)
				set_order(directed[i].val[4:0]);
			else
				send(directed[i].act, directed[i].pos, directed[i].val, directed[i].n,
					directed[i].typed, directed[i].term);
		end

		foreach (phase_orders[p]) begin
			set_order(5'(phase_orders[p]));
			case (p % 4)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 81; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 81; end
				default: begin idle_pct = 7; stall_pct = 7; end
			endcase
			m = phase_orders[p];
			sent = 0;
			while (sent < 13) begin
				// Now and then hold off until every term has come back.
				if ($urandom_range(0, 99) < 5) begin
					in_valid <= 1'b0;
					@(posedge clk);
					while (pending_terms.size() != 0)
						@(posedge clk);
				end
				pick = $urandom_range(0, 99);
				if ($urandom_range(0, 99) < 85)
					val = 30'($urandom_range(0, 1000000006));
				else
					val = 30'($urandom_range(1000000007, 30'h3fffffff));
				if (pick < 45) begin
					send((pick < 22) ? ACT_LOAD_COEF : ACT_LOAD_INIT,
						4'($urandom_range(0, 15)), val, 63'({$urandom, $urandom}), 0, '0);
					sent++;
				end else if (pick < 50) begin
					send(ACT_UNUSED, 4'($urandom), val, 63'({$urandom, $urandom}), 0, '0);
				end else begin
					// Long exponents only at low order, to keep the run short.
					if ($urandom_range(0, 3) == 0)
						n = 63'($urandom_range(0, m + 2));
					else begin
						bits = (m <= 3) ? $urandom_range(1, 63) : $urandom_range(1, 12);
						n = 63'({$urandom, $urandom}) & ((63'd1 << bits) - 63'd1);
						if (bits == 63)
							n = 63'({$urandom, $urandom});
					end
					send(ACT_QUERY, 4'($urandom), val, n, 0, '0);
					sent++;
				end
			end
		end

		drain();
		if (fails == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
